>>> sv/ogr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ogr_pkg;
    localparam int GRID_W = 256;
    localparam int GRID_H = 256;
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam int AW = XW + YW;
    localparam int DEPTH = GRID_W * GRID_H;

    localparam logic [1:0] OP_RAY    = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_HIT      = 3'd2;
    localparam logic [2:0] CFG_MISS     = 3'd3;
    localparam logic [2:0] CFG_LOG_MIN  = 3'd4;
    localparam logic [2:0] CFG_LOG_MAX  = 3'd5;
    localparam logic [2:0] CFG_OCC      = 3'd6;
    localparam logic [2:0] CFG_FREE     = 3'd7;

    localparam logic [1:0] CLASS_FREE     = 2'd0;
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd1;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

    localparam logic [9:0] COUNT_MAX = 10'd1023;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               hit;
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
    } item_t;

    typedef struct packed {
        logic signed [7:0] cell_value;
        logic [1:0]        cell_class;
        logic              out_of_map;
        logic [9:0]        cells_updated;
        logic              reached_end;
    } result_t;

    typedef struct packed {
        logic [8:0]        grid_width;
        logic [8:0]        grid_height;
        logic [4:0]        hit_step;
        logic signed [5:0] miss_step;
        logic signed [7:0] log_min;
        logic [6:0]        log_max;
        logic signed [7:0] occupied_above;
        logic signed [7:0] free_below;
    } cfg_t;

    // radius-2 disc, 13 cells: x offset outer, y offset inner, both ascending
    localparam int DISC_N = 13;
    function automatic logic signed [2:0] disc_dy(input logic [3:0] i);
        case (i)
            4'd0: disc_dy = 3'sd0;
            4'd1: disc_dy = -3'sd1;  4'd2: disc_dy = 3'sd0;  4'd3: disc_dy = 3'sd1;
            4'd4: disc_dy = -3'sd2;  4'd5: disc_dy = -3'sd1; 4'd6: disc_dy = 3'sd0;
            4'd7: disc_dy = 3'sd1;   4'd8: disc_dy = 3'sd2;
            4'd9: disc_dy = -3'sd1;  4'd10: disc_dy = 3'sd0; 4'd11: disc_dy = 3'sd1;
            4'd12: disc_dy = 3'sd0;
            default: disc_dy = 3'sd0;
        endcase
    endfunction
    // x offsets in the same order: -2 once, -1 three times, 0 five times, ...
    function automatic logic signed [2:0] disc_ax(input logic [3:0] i);
        case (i)
            4'd0: disc_ax = -3'sd2;
            4'd1, 4'd2, 4'd3: disc_ax = -3'sd1;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8: disc_ax = 3'sd0;
            4'd9, 4'd10, 4'd11: disc_ax = 3'sd1;
            4'd12: disc_ax = 3'sd2;
            default: disc_ax = 3'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> sv/ogr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ogr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/ogr_cell_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// saturating add of a step to a cell value
module ogr_cell_alu (
    input  wire logic signed [7:0] old_value,
    input  wire logic signed [5:0] step,
    input  wire logic signed [7:0] log_min,
    input  wire logic        [6:0] log_max,
    output logic signed      [7:0] new_value
);
    logic signed [9:0] sum;
    logic signed [9:0] lo;

    always_comb
    begin
        sum = 10'(old_value) + 10'(step);
        lo  = (sum < 10'(log_min)) ? 10'(log_min) : sum;
        if (lo > $signed({3'b000, log_max}))
        begin
            new_value = $signed({1'b0, log_max});
        end
        else
        begin
            new_value = lo[7:0];
        end
    end
endmodule
`default_nettype wire

>>> sv/occupancy_grid_ray_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Occupancy grid ray update unit.
// Items enter on start/item at an edge where busy is low; each transaction
// gives one result on result, with result_valid high for exactly one cycle.
// The receiver cannot stall, so a result is never held back.
// Config: cfg_we/cfg_index/cfg_data, to be written only while idle; the
// block does not enforce this. All cell updates share one grid RAM port
// and one saturating adder (read, then write). A new item is taken only
// when the previous one is done and busy is low. Per operation:
//   ray: each miss cell walked is read, then written (at most 256 cells
//   lie on a walk); a hit at an in-map end then updates the hit cell and
//   each in-map disc cell; disc cells off the map are skipped.
//   clear: one cell per cycle over 65536 cells.
// Reset: the config, state and address registers and result_valid take
// their defaults at once; a clearing pass over all 65536 cells runs after
// rst_n rises, with busy high and no result.
module occupancy_grid_ray_update_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ogr_pkg::item_t  item,
    output logic                 busy,
    output logic                 result_valid,
    output ogr_pkg::result_t     result,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [8:0]      cfg_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_RDOUT  = 4'd3;
    localparam logic [3:0] S_WCHK   = 4'd4;
    localparam logic [3:0] S_WRD    = 4'd5;
    localparam logic [3:0] S_WWR    = 4'd6;
    localparam logic [3:0] S_DCHK   = 4'd7;
    localparam logic [3:0] S_DRD    = 4'd8;
    localparam logic [3:0] S_DWR    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // disc index marker: err not yet set, or hit-cell write pending
    localparam logic [3:0] DIDX_NONE = 4'd15;

    ogr_pkg::cfg_t cfg_reg;
    logic [3:0] state_reg;
    logic signed [16:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [17:0] dx_reg, dy_reg, err_reg;
    logic sx_reg, sy_reg, hit_reg;
    logic [3:0] didx_reg;
    logic [9:0] cnt_reg;
    logic reached_reg;
    logic [ogr_pkg::AW-1:0] addr_reg;
    logic signed [5:0] step_reg;
    logic [7:0] rd_x_reg, rd_y_reg;
    logic busy_item_reg;

    logic ram_we;
    logic [ogr_pkg::AW-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;
    logic signed [7:0] alu_out;

    logic [8:0] eff_w, eff_h;
    assign eff_w = (cfg_reg.grid_width < 9'(ogr_pkg::GRID_W))
                   ? cfg_reg.grid_width : 9'(ogr_pkg::GRID_W);
    assign eff_h = (cfg_reg.grid_height < 9'(ogr_pkg::GRID_H))
                   ? cfg_reg.grid_height : 9'(ogr_pkg::GRID_H);

    function automatic logic in_map(input logic signed [16:0] x, input logic signed [16:0] y,
                                    input logic [8:0] w, input logic [8:0] h);
        in_map = (x >= 0) && (y >= 0) && (x < $signed({8'd0, w}))
                 && (y < $signed({8'd0, h}));
    endfunction

    logic signed [16:0] dxc, dyc;
    logic disc_in;
    logic walk_in;
    logic signed [18:0] e2;
    assign dxc = x1_reg + 17'(ogr_pkg::disc_ax(didx_reg));
    assign dyc = y1_reg + 17'(ogr_pkg::disc_dy(didx_reg));
    assign disc_in = in_map(dxc, dyc, eff_w, eff_h);
    assign walk_in = in_map(x_reg, y_reg, eff_w, eff_h);
    assign e2 = {err_reg, 1'b0};

    ogr_ram #(.WIDTH(8), .DEPTH(ogr_pkg::DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ogr_cell_alu u_alu (
        .old_value(ram_rdata),
        .step     (step_reg),
        .log_min  (cfg_reg.log_min),
        .log_max  (cfg_reg.log_max),
        .new_value(alu_out)
    );

    assign ram_raddr = addr_reg;
    assign ram_waddr = addr_reg;
    assign ram_we = (state_reg == S_CLEAR) || (state_reg == S_WWR) || (state_reg == S_DWR);
    assign ram_wdata = (state_reg == S_CLEAR) ? 8'd0 : alu_out;
    assign busy = (state_reg != S_IDLE);

    logic signed [7:0] rv;
    assign rv = ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{9'd256, 9'd256, 5'd4, -6'sd1, -8'sd8, 7'd16, 8'sd4, -8'sd2};
            state_reg <= S_CLEAR;
            addr_reg <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= (state_reg == S_RDOUT) || (state_reg == S_DONE && busy_item_reg);
            if (cfg_we)
            begin
                case (cfg_index)
                    ogr_pkg::CFG_WIDTH:   cfg_reg.grid_width <= cfg_data;
                    ogr_pkg::CFG_HEIGHT:  cfg_reg.grid_height <= cfg_data;
                    ogr_pkg::CFG_HIT:     cfg_reg.hit_step <= cfg_data[4:0];
                    ogr_pkg::CFG_MISS:    cfg_reg.miss_step <= cfg_data[5:0];
                    ogr_pkg::CFG_LOG_MIN: cfg_reg.log_min <= cfg_data[7:0];
                    ogr_pkg::CFG_LOG_MAX: cfg_reg.log_max <= cfg_data[6:0];
                    ogr_pkg::CFG_OCC:     cfg_reg.occupied_above <= cfg_data[7:0];
                    ogr_pkg::CFG_FREE:    cfg_reg.free_below <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        result <= '0;
                        cnt_reg <= '0;
                        reached_reg <= 1'b0;
                        case (item.op)
                            ogr_pkg::OP_RAY:
                            begin
                                x_reg <= 17'(item.start_x);
                                y_reg <= 17'(item.start_y);
                                x1_reg <= 17'(item.end_x);
                                y1_reg <= 17'(item.end_y);
                                dx_reg <= (item.end_x > item.start_x)
                                    ? 18'(item.end_x) - 18'(item.start_x)
                                    : 18'(item.start_x) - 18'(item.end_x);
                                dy_reg <= (item.end_y > item.start_y)
                                    ? 18'(item.end_y) - 18'(item.start_y)
                                    : 18'(item.start_y) - 18'(item.end_y);
                                sx_reg <= item.start_x < item.end_x;
                                sy_reg <= item.start_y < item.end_y;
                                hit_reg <= item.hit;
                                state_reg <= S_WCHK;
                                err_reg <= '0;
                                didx_reg <= DIDX_NONE;
                            end
                            ogr_pkg::OP_READ:
                            begin
                                rd_x_reg <= item.cell_x;
                                rd_y_reg <= item.cell_y;
                                addr_reg <= {item.cell_y[ogr_pkg::YW-1:0],
                                             item.cell_x[ogr_pkg::XW-1:0]};
                                state_reg <= S_RDWAIT;
                            end
                            ogr_pkg::OP_CLEAR:
                            begin
                                addr_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + {{(ogr_pkg::AW-1){1'b0}}, 1'b1};
                    if (addr_reg == '1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RDWAIT: state_reg <= S_RDOUT;
                S_RDOUT:
                begin
                    if (!in_map({9'd0, rd_x_reg}, {9'd0, rd_y_reg}, eff_w, eff_h))
                    begin
                        result.out_of_map <= 1'b1;
                        result.cell_class <= ogr_pkg::CLASS_UNKNOWN;
                    end
                    else
                    begin
                        result.cell_value <= rv;
                        result.cell_class <= (rv > cfg_reg.occupied_above)
                            ? ogr_pkg::CLASS_OCCUPIED
                            : ((rv < cfg_reg.free_below) ? ogr_pkg::CLASS_FREE
                                                         : ogr_pkg::CLASS_UNKNOWN);
                    end
                    state_reg <= S_IDLE;
                end
                S_WCHK:
                begin
                    if (didx_reg == DIDX_NONE)
                    begin
                        err_reg <= dx_reg - dy_reg;
                        didx_reg <= 4'd0;
                    end
                    else if (!walk_in)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (x_reg == x1_reg && y_reg == y1_reg)
                    begin
                        reached_reg <= 1'b1;
                        if (hit_reg)
                        begin
                            addr_reg <= {y_reg[ogr_pkg::YW-1:0], x_reg[ogr_pkg::XW-1:0]};
                            step_reg <= {1'b0, cfg_reg.hit_step};
                            didx_reg <= DIDX_NONE;
                            state_reg <= S_DRD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        addr_reg <= {y_reg[ogr_pkg::YW-1:0], x_reg[ogr_pkg::XW-1:0]};
                        step_reg <= cfg_reg.miss_step;
                        state_reg <= S_WRD;
                    end
                end
                S_WRD: state_reg <= S_WWR;
                S_WWR:
                begin
                    if (cnt_reg != ogr_pkg::COUNT_MAX) cnt_reg <= cnt_reg + 10'd1;
                    begin
                        logic signed [17:0] en;
                        en = err_reg;
                        if (e2 > -19'(dy_reg))
                        begin
                            en = en - dy_reg;
                            x_reg <= sx_reg ? x_reg + 17'sd1 : x_reg - 17'sd1;
                        end
                        if (e2 < 19'(dx_reg))
                        begin
                            en = en + dx_reg;
                            y_reg <= sy_reg ? y_reg + 17'sd1 : y_reg - 17'sd1;
                        end
                        err_reg <= en;
                    end
                    state_reg <= S_WCHK;
                end
                S_DCHK:
                begin
                    step_reg <= {2'b00, cfg_reg.hit_step[4:1]};
                    addr_reg <= {dyc[ogr_pkg::YW-1:0], dxc[ogr_pkg::XW-1:0]};
                    if (disc_in)
                    begin
                        state_reg <= S_DRD;
                    end
                    else if (didx_reg == 4'(ogr_pkg::DISC_N - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        didx_reg <= didx_reg + 4'd1;
                    end
                end
                S_DRD: state_reg <= S_DWR;
                S_DWR:
                begin
                    if (cnt_reg != ogr_pkg::COUNT_MAX) cnt_reg <= cnt_reg + 10'd1;
                    if (didx_reg == DIDX_NONE)
                    begin
                        // hit cell written; the disc follows, centre included
                        didx_reg <= 4'd0;
                        state_reg <= S_DCHK;
                    end
                    else if (didx_reg == 4'(ogr_pkg::DISC_N - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        didx_reg <= didx_reg + 4'd1;
                        state_reg <= S_DCHK;
                    end
                end
                S_DONE:
                begin
                    result.reached_end <= reached_reg;
                    result.cells_updated <= cnt_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result for reset clear is suppressed; only real transactions report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_item_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE && start)
        begin
            busy_item_reg <= 1'b1;
        end
    end

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result strobe held");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy) else $error("busy with result");
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy) else $error("write while idle");
endmodule
`default_nettype wire
